// ----- hw/rtl/bpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery power policy package
// Shared types, codes and levels for the power policy core and its checker.
// ----------------------------------------------------------------------------
package bpp_pkg;

    typedef enum logic [2:0] {
        EV_PROFILE  = 3'd0,
        EV_AC       = 3'd1,
        EV_CHARGE   = 3'd2,
        EV_FULL     = 3'd3,
        EV_CRITICAL = 3'd4,
        EV_REMINDER = 3'd5
    } event_code_t;

    typedef enum logic [1:0] {
        PROF_SAVER    = 2'd0,
        PROF_BALANCED = 2'd1,
        PROF_PERF     = 2'd2,
        PROF_UNKNOWN  = 2'd3
    } profile_t;

    typedef enum logic [1:0] {
        URG_LOW      = 2'd0,
        URG_NORMAL   = 2'd1,
        URG_CRITICAL = 2'd2,
        URG_NONE     = 2'd3
    } urgency_t;

    typedef enum logic [1:0] {
        CFG_POLICY_ENABLED  = 2'd0,
        CFG_SAVER_MAX       = 2'd1,
        CFG_BALANCED_MAX    = 2'd2,
        CFG_PERFORMANCE_MIN = 2'd3
    } cfg_index_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_MINUTE = 1'b1;

    localparam logic [6:0] BRIGHT_SAVER    = 7'd20;
    localparam logic [6:0] BRIGHT_BALANCED = 7'd50;
    localparam logic [6:0] BRIGHT_PERF     = 7'd65;

    localparam logic signed [7:0] CHARGE_LEVEL   = 8'sd80;
    localparam logic signed [7:0] FULL_LEVEL     = 8'sd100;
    localparam logic signed [7:0] CRITICAL_LEVEL = 8'sd20;

    localparam logic [5:0] REMINDER_MINUTES = 6'd20;
    localparam logic [5:0] MINUTES_MAX      = 6'd63;

    localparam logic [6:0] SAVER_LIMIT    = 7'd98;
    localparam logic [6:0] BALANCED_LIMIT = 7'd99;
    localparam logic [6:0] PERF_LIMIT     = 7'd100;

    localparam int unsigned MAX_EVENTS = 4;

    typedef struct packed {
        event_code_t      code;
        profile_t         profile;
        logic [6:0]       brightness;
        urgency_t         urgency;
        logic signed [7:0] capacity;
    } event_t;

    function automatic event_t make_event(event_code_t code, profile_t prof,
                                          logic [6:0] bright, urgency_t urg,
                                          logic signed [7:0] cap);
        event_t e;
        e.code       = code;
        e.profile    = prof;
        e.brightness = bright;
        e.urgency    = urg;
        e.capacity   = cap;
        return e;
    endfunction

endpackage

// ----- hw/rtl/battery_power_policy_core.sv -----
// ----------------------------------------------------------------------------
// Battery power policy core
// Picks a power profile from battery samples, raises an on-AC notice, one-shot
// charge, full and critical alerts and an on-AC reminder, all emitted as ordered words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    req_type, sample_valid, on_battery, capacity
//  m_        out        m_valid / m_ready    event fields, last_event
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  An accepted word is evaluated combinationally from the input register and its
//  events (up to three) load an event buffer that drains one word per cycle while
//  m_ready is high. A word with events holds the buffer until its last is taken.
//  Input and output sides overlap, so a new word is taken while the last event
//  of the previous one is being handed over.
//  Reset is synchronous, active low; a stalled m_ side holds the buffer.
// ----------------------------------------------------------------------------
module battery_power_policy_core (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic              s_sample_valid,
    input  logic              s_on_battery,
    input  logic signed [7:0] s_capacity,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_event_code,
    output logic [1:0]        m_profile,
    output logic [6:0]        m_brightness,
    output logic [1:0]        m_urgency,
    output logic signed [7:0] m_event_capacity,
    output logic              m_last_event,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);
    import bpp_pkg::*;

    // configuration
    logic       policy_enabled_reg;
    logic [6:0] saver_max_reg;
    logic [6:0] balanced_max_reg;
    logic [6:0] performance_min_reg;

    // input register
    logic              in_valid_reg;
    logic              in_type_reg;
    logic              in_sample_valid_reg;
    logic              in_batt_reg;
    logic signed [7:0] in_cap_reg;

    // policy state
    logic       seen_valid_reg,       seen_valid_next;
    logic       last_batt_reg,        last_batt_next;
    logic [7:0] last_cap_reg,         last_cap_next;
    profile_t   active_profile_reg,   active_profile_next;
    logic       charge_alerted_reg,   charge_alerted_next;
    logic       full_alerted_reg,     full_alerted_next;
    logic       critical_alerted_reg, critical_alerted_next;
    logic [5:0] minutes_reg,          minutes_next;

    // event buffer
    event_t     ev_buf_reg [MAX_EVENTS];
    logic [2:0] ev_cnt_reg;
    logic [1:0] rd_idx_reg;

    event_t     ev_slot [MAX_EVENTS];
    logic [2:0] ev_cnt;

    logic [6:0] s_eff, s_plus1, b_eff, b_plus1, p_eff;
    logic signed [7:0] s_thr, p_thr;
    profile_t   target;
    logic [6:0] bright;
    logic       take, last_take, consume;
    logic [1:0] last_idx;

    assign cfg_ready = 1'b1;

    // effective thresholds, each clamped above the one below
    always_comb begin
        s_eff   = (saver_max_reg > SAVER_LIMIT) ? SAVER_LIMIT : saver_max_reg;
        s_plus1 = s_eff + 7'd1;
        if (balanced_max_reg < s_plus1) begin
            b_eff = s_plus1;
        end else if (balanced_max_reg > BALANCED_LIMIT) begin
            b_eff = BALANCED_LIMIT;
        end else begin
            b_eff = balanced_max_reg;
        end
        b_plus1 = b_eff + 7'd1;
        if (performance_min_reg < b_plus1) begin
            p_eff = b_plus1;
        end else if (performance_min_reg > PERF_LIMIT) begin
            p_eff = PERF_LIMIT;
        end else begin
            p_eff = performance_min_reg;
        end
        s_thr = $signed({1'b0, s_eff});
        p_thr = $signed({1'b0, p_eff});
    end

    always_comb begin
        priority if (!in_batt_reg) begin
            target = PROF_PERF;
            bright = BRIGHT_PERF;
        end else if (in_cap_reg <= s_thr) begin
            target = PROF_SAVER;
            bright = BRIGHT_SAVER;
        end else if (in_cap_reg >= p_thr) begin
            target = PROF_PERF;
            bright = BRIGHT_PERF;
        end else begin
            target = PROF_BALANCED;
            bright = BRIGHT_BALANCED;
        end
    end

    // handshake and buffer control
    assign last_idx  = ev_cnt_reg[1:0] - 2'd1;
    assign m_valid   = (ev_cnt_reg != 3'd0);
    assign take      = m_valid && m_ready;
    assign last_take = take && (rd_idx_reg == last_idx);
    assign consume   = in_valid_reg && (!m_valid || last_take);
    assign s_ready   = !in_valid_reg || consume;

    // event evaluation and next state
    always_comb begin
        logic flipped;
        logic cap_changed;
        urgency_t prof_urg;

        seen_valid_next       = seen_valid_reg;
        last_batt_next        = last_batt_reg;
        last_cap_next         = last_cap_reg;
        active_profile_next   = active_profile_reg;
        charge_alerted_next   = charge_alerted_reg;
        full_alerted_next     = full_alerted_reg;
        critical_alerted_next = critical_alerted_reg;
        minutes_next          = minutes_reg;
        ev_cnt                = 3'd0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_slot[i] = '0;
        end
        flipped     = (in_batt_reg != last_batt_reg);
        cap_changed = (in_cap_reg != $signed(last_cap_reg));
        prof_urg    = (in_batt_reg && (in_cap_reg <= s_thr)) ? URG_CRITICAL : URG_LOW;

        if (in_type_reg == REQ_MINUTE) begin
            if (minutes_reg != MINUTES_MAX) begin
                minutes_next = minutes_reg + 6'd1;
            end
        end else if (in_sample_valid_reg) begin
            if (!seen_valid_reg) begin
                // first usable read: apply the profile with URG_NONE and raise no alerts
                if (policy_enabled_reg && (active_profile_reg != target)) begin
                    active_profile_next = target;
                    ev_slot[ev_cnt[1:0]] = make_event(EV_PROFILE, target, bright,
                                                      URG_NONE, in_cap_reg);
                    ev_cnt = ev_cnt + 3'd1;
                end
                if (!in_batt_reg) begin
                    minutes_next = '0;
                end
            end else if (flipped || cap_changed) begin
                if (flipped) begin
                    minutes_next = '0;
                    if (!in_batt_reg) begin
                        critical_alerted_next = 1'b0;
                        ev_slot[ev_cnt[1:0]] = make_event(EV_AC, PROF_SAVER, 7'd0,
                                                          URG_LOW, in_cap_reg);
                        ev_cnt = ev_cnt + 3'd1;
                    end else begin
                        charge_alerted_next = 1'b0;
                        full_alerted_next   = 1'b0;
                    end
                end
                if (policy_enabled_reg && (active_profile_reg != target)) begin
                    active_profile_next = target;
                    ev_slot[ev_cnt[1:0]] = make_event(EV_PROFILE, target, bright,
                                                      prof_urg, in_cap_reg);
                    ev_cnt = ev_cnt + 3'd1;
                end
                if (!in_batt_reg) begin
                    if (!charge_alerted_next && (in_cap_reg >= CHARGE_LEVEL)
                        && (in_cap_reg < FULL_LEVEL)) begin
                        charge_alerted_next = 1'b1;
                        ev_slot[ev_cnt[1:0]] = make_event(EV_CHARGE, PROF_SAVER, 7'd0,
                                                          URG_NORMAL, in_cap_reg);
                        ev_cnt = ev_cnt + 3'd1;
                    end
                    if (!full_alerted_next && (in_cap_reg >= FULL_LEVEL)) begin
                        full_alerted_next = 1'b1;
                        ev_slot[ev_cnt[1:0]] = make_event(EV_FULL, PROF_SAVER, 7'd0,
                                                          URG_NORMAL, in_cap_reg);
                        ev_cnt = ev_cnt + 3'd1;
                    end
                    if ((in_cap_reg >= CHARGE_LEVEL) && (minutes_next >= REMINDER_MINUTES)) begin
                        minutes_next = '0;
                        ev_slot[ev_cnt[1:0]] = make_event(EV_REMINDER, PROF_SAVER, 7'd0,
                                                          URG_NORMAL, in_cap_reg);
                        ev_cnt = ev_cnt + 3'd1;
                    end
                end else if (!critical_alerted_reg && (in_cap_reg <= CRITICAL_LEVEL)) begin
                    critical_alerted_next = 1'b1;
                    ev_slot[ev_cnt[1:0]] = make_event(EV_CRITICAL, PROF_SAVER, 7'd0,
                                                      URG_CRITICAL, in_cap_reg);
                    ev_cnt = ev_cnt + 3'd1;
                end
            end else if (!in_batt_reg) begin
                if ((in_cap_reg >= CHARGE_LEVEL) && (minutes_reg >= REMINDER_MINUTES)) begin
                    minutes_next = '0;
                    ev_slot[ev_cnt[1:0]] = make_event(EV_REMINDER, PROF_SAVER, 7'd0,
                                                      URG_NORMAL, in_cap_reg);
                    ev_cnt = ev_cnt + 3'd1;
                end
            end
            seen_valid_next = 1'b1;
            last_batt_next  = in_batt_reg;
            last_cap_next   = in_cap_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_enabled_reg  <= 1'b1;
            saver_max_reg       <= 7'd20;
            balanced_max_reg    <= 7'd59;
            performance_min_reg <= 7'd60;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_POLICY_ENABLED:  policy_enabled_reg  <= cfg_data[0];
                CFG_SAVER_MAX:       saver_max_reg       <= cfg_data;
                CFG_BALANCED_MAX:    balanced_max_reg    <= cfg_data;
                CFG_PERFORMANCE_MIN: performance_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg         <= s_req_type;
            in_sample_valid_reg <= s_sample_valid;
            in_batt_reg         <= s_on_battery;
            in_cap_reg          <= s_capacity;
        end
    end

    // policy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_valid_reg       <= 1'b0;
            last_batt_reg        <= 1'b0;
            last_cap_reg         <= 8'hFF;
            active_profile_reg   <= PROF_UNKNOWN;
            charge_alerted_reg   <= 1'b0;
            full_alerted_reg     <= 1'b0;
            critical_alerted_reg <= 1'b0;
            minutes_reg          <= '0;
        end else if (consume) begin
            seen_valid_reg       <= seen_valid_next;
            last_batt_reg        <= last_batt_next;
            last_cap_reg         <= last_cap_next;
            active_profile_reg   <= active_profile_next;
            charge_alerted_reg   <= charge_alerted_next;
            full_alerted_reg     <= full_alerted_next;
            critical_alerted_reg <= critical_alerted_next;
            minutes_reg          <= minutes_next;
        end
    end

    // event buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_cnt_reg <= '0;
            rd_idx_reg <= '0;
        end else if (consume) begin
            ev_cnt_reg <= ev_cnt;
            rd_idx_reg <= '0;
        end else if (last_take) begin
            ev_cnt_reg <= '0;
            rd_idx_reg <= '0;
        end else if (take) begin
            rd_idx_reg <= rd_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            for (int i = 0; i < MAX_EVENTS; i++) begin
                ev_buf_reg[i] <= ev_slot[i];
            end
        end
    end

    assign m_event_code     = ev_buf_reg[rd_idx_reg].code;
    assign m_profile        = ev_buf_reg[rd_idx_reg].profile;
    assign m_brightness     = ev_buf_reg[rd_idx_reg].brightness;
    assign m_urgency        = ev_buf_reg[rd_idx_reg].urgency;
    assign m_event_capacity = ev_buf_reg[rd_idx_reg].capacity;
    assign m_last_event     = (rd_idx_reg == last_idx);

endmodule

// ----- hw/rtl/bpp_checker.sv -----
// ----------------------------------------------------------------------------
// Battery power policy checker
// Port-level checks on the event stream of the power policy core.
// ----------------------------------------------------------------------------
module bpp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_event_code,
    input logic [1:0]        m_profile,
    input logic [6:0]        m_brightness,
    input logic [1:0]        m_urgency,
    input logic signed [7:0] m_event_capacity,
    input logic              m_last_event
);
    import bpp_pkg::*;

    // a stalled event word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code)
            && $stable(m_event_capacity) && $stable(m_last_event))
        else $error("stalled event word changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_code <= EV_REMINDER))
        else $error("event code out of range");

    // only profile changes carry a profile and brightness
    a_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code != EV_PROFILE) |-> (m_profile == 2'd0)
            && (m_brightness == 7'd0))
        else $error("alert word carries profile fields");

    a_bright: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == EV_PROFILE) |->
            ((m_profile == PROF_SAVER) && (m_brightness == BRIGHT_SAVER))
            || ((m_profile == PROF_BALANCED) && (m_brightness == BRIGHT_BALANCED))
            || ((m_profile == PROF_PERF) && (m_brightness == BRIGHT_PERF)))
        else $error("profile and brightness disagree");

    a_crit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == EV_CRITICAL) |-> (m_urgency == URG_CRITICAL)
            && (m_event_capacity <= CRITICAL_LEVEL))
        else $error("critical alert malformed");

endmodule

bind battery_power_policy_core bpp_checker u_bpp_checker (.*);

// ----- sim/tb_battery_power_policy_core.sv -----
// ----------------------------------------------------------------------------
// Battery power policy core testbench
// Drives samples and minute ticks through the s_ channel, writes the policy
// registers between phases, and checks every m_ word against typed words or a
// cycle-free model of the policy kept in this file. A directed table comes first,
// then random supply walks under three idling mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_battery_power_policy_core;
    import bpp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int SHOW_MAX = 10;

    typedef struct packed {
        event_code_t       code;
        profile_t          prof;
        logic [6:0]        bright;
        urgency_t          urg;
        logic signed [7:0] cap;
        logic              last;
    } ev_word_t;

    // one directed row; n_typed < 0 means the model supplies the words
    typedef struct packed {
        logic       req;
        logic       ok;
        logic       batt;
        logic [7:0] cap;
        int         reps;
        int         n_typed;
        ev_word_t   typed;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_req_type = REQ_SAMPLE;
    logic              s_sample_valid = 1'b0;
    logic              s_on_battery = 1'b0;
    logic signed [7:0] s_capacity = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_event_code;
    logic [1:0]        m_profile;
    logic [6:0]        m_brightness;
    logic [1:0]        m_urgency;
    logic signed [7:0] m_event_capacity;
    logic              m_last_event;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_POLICY_ENABLED;
    logic [6:0]        cfg_data = '0;

    // policy registers as the block should hold them
    bit        pol_enabled = 1'b1;
    int        pol_saver_max = 20;
    int        pol_balanced_max = 59;
    int        pol_perf_min = 60;

    // policy state
    bit        seen_valid = 1'b0;
    bit        last_batt = 1'b0;
    logic [7:0] last_cap = 8'hFF;
    profile_t  active_prof = PROF_UNKNOWN;
    bit        charge_alerted = 1'b0;
    bit        full_alerted = 1'b0;
    bit        critical_alerted = 1'b0;
    int        minutes_on_ac = 0;

    ev_word_t  step_events[$];
    ev_word_t  due_events[$];
    stim_row_t stim_table[$];

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // random supply walk
    bit        walk_batt = 1'b0;
    int        walk_soc = 50;

    battery_power_policy_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_sample_valid   (s_sample_valid),
        .s_on_battery     (s_on_battery),
        .s_capacity       (s_capacity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_code     (m_event_code),
        .m_profile        (m_profile),
        .m_brightness     (m_brightness),
        .m_urgency        (m_urgency),
        .m_event_capacity (m_event_capacity),
        .m_last_event     (m_last_event),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_battery_power_policy_core: FAIL");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off counted down here
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic ev_word_t make_word(event_code_t code, profile_t prof,
                                           logic [6:0] bright, urgency_t urg,
                                           logic [7:0] cap, logic last);
        ev_word_t w;
        w.code   = code;
        w.prof   = prof;
        w.bright = bright;
        w.urg    = urg;
        w.cap    = cap;
        w.last   = last;
        return w;
    endfunction

    function automatic void note_event(ev_word_t w);
        step_events.insert(step_events.size(), w);
    endfunction

    function automatic void expect_event(ev_word_t w);
        due_events.insert(due_events.size(), w);
    endfunction

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit reminder_due(int cap);
        if (cap < CHARGE_LEVEL || minutes_on_ac < REMINDER_MINUTES) return 1'b0;
        minutes_on_ac = 0;
        return 1'b1;
    endfunction

    // works out the words one input causes and advances the policy state
    function automatic void derive_policy_events(logic req, logic ok, logic batt,
                                                 logic [7:0] cap_bits);
        int         cap;
        int         s_eff;
        int         b_eff;
        int         p_eff;
        profile_t   target;
        logic [6:0] bright;
        bit         flipped;

        step_events.delete();
        cap   = int'($signed(cap_bits));
        s_eff = clamp_to(pol_saver_max, 0, SAVER_LIMIT);
        b_eff = clamp_to(pol_balanced_max, s_eff + 1, BALANCED_LIMIT);
        p_eff = clamp_to(pol_perf_min, b_eff + 1, PERF_LIMIT);

        if (req == REQ_MINUTE) begin
            if (minutes_on_ac < MINUTES_MAX) minutes_on_ac++;
            return;
        end
        if (!ok) return;

        if (!batt) begin
            target = PROF_PERF;
            bright = BRIGHT_PERF;
        end else if (cap <= s_eff) begin
            target = PROF_SAVER;
            bright = BRIGHT_SAVER;
        end else if (cap >= p_eff) begin
            target = PROF_PERF;
            bright = BRIGHT_PERF;
        end else begin
            target = PROF_BALANCED;
            bright = BRIGHT_BALANCED;
        end

        if (!seen_valid) begin
            // first usable read sets the profile with URG_NONE and raises no alerts
            if (pol_enabled && active_prof != target) begin
                active_prof = target;
                note_event(make_word(EV_PROFILE, target, bright, URG_NONE,
                                     cap_bits, 1'b0));
            end
            if (!batt) minutes_on_ac = 0;
        end else if (batt != last_batt || cap_bits != last_cap) begin
            flipped = (batt != last_batt);
            if (flipped && !batt) begin
                critical_alerted = 1'b0;
                minutes_on_ac = 0;
                note_event(make_word(EV_AC, PROF_SAVER, '0, URG_LOW,
                                     cap_bits, 1'b0));
            end else if (flipped) begin
                charge_alerted = 1'b0;
                full_alerted = 1'b0;
                minutes_on_ac = 0;
            end
            if (pol_enabled && active_prof != target) begin
                active_prof = target;
                note_event(make_word(EV_PROFILE, target, bright,
                    (batt && cap <= s_eff) ? URG_CRITICAL : URG_LOW, cap_bits, 1'b0));
            end
            if (!batt) begin
                if (!charge_alerted && cap >= CHARGE_LEVEL && cap < FULL_LEVEL) begin
                    charge_alerted = 1'b1;
                    note_event(make_word(EV_CHARGE, PROF_SAVER, '0,
                                         URG_NORMAL, cap_bits, 1'b0));
                end
                if (!full_alerted && cap >= FULL_LEVEL) begin
                    full_alerted = 1'b1;
                    note_event(make_word(EV_FULL, PROF_SAVER, '0,
                                         URG_NORMAL, cap_bits, 1'b0));
                end
                if (reminder_due(cap))
                    note_event(make_word(EV_REMINDER, PROF_SAVER, '0,
                                         URG_NORMAL, cap_bits, 1'b0));
            end else if (!critical_alerted && cap <= CRITICAL_LEVEL) begin
                // fixed critical level, independent of saver_max
                critical_alerted = 1'b1;
                note_event(make_word(EV_CRITICAL, PROF_SAVER, '0,
                                     URG_CRITICAL, cap_bits, 1'b0));
            end
        end else if (!batt) begin
            if (reminder_due(cap))
                note_event(make_word(EV_REMINDER, PROF_SAVER, '0,
                                     URG_NORMAL, cap_bits, 1'b0));
        end

        seen_valid = 1'b1;
        last_batt = batt;
        last_cap = cap_bits;
        if (step_events.size() != 0) begin
            step_events[step_events.size() - 1].last = 1'b1;
        end
    endfunction

    // result checker: oldest expectation first
    always @(posedge aclk) begin : check_events
        ev_word_t got;
        ev_word_t want;
        if (aresetn && m_valid && m_ready) begin
            got = make_word(event_code_t'(m_event_code), profile_t'(m_profile),
                            m_brightness, urgency_t'(m_urgency), m_event_capacity,
                            m_last_event);
            if (due_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("unexpected word: code %0d prof %0d bright %0d",
                             got.code, got.prof, got.bright,
                             " urg %0d cap %0d last %0d", got.urg, got.cap, got.last);
            end else begin
                want = due_events.pop_front();
                if (got.code !== want.code || got.prof !== want.prof ||
                    got.bright !== want.bright || got.urg !== want.urg ||
                    got.cap !== want.cap || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("word mismatch: exp code %0d prof %0d bright %0d",
                                 want.code, want.prof, want.bright,
                                 " urg %0d cap %0d last %0d", want.urg, want.cap,
                                 want.last,
                                 " / got code %0d prof %0d bright %0d",
                                 got.code, got.prof, got.bright,
                                 " urg %0d cap %0d last %0d", got.urg, got.cap,
                                 got.last);
                end
            end
        end
    end

    // holds valid and payload until the word is taken
    task automatic offer_word(logic req, logic ok, logic batt, logic [7:0] cap);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_sample_valid <= ok;
        s_on_battery   <= batt;
        s_capacity     <= cap;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_word(logic req, logic ok, logic batt, logic [7:0] cap);
        offer_word(req, ok, batt, cap);
        derive_policy_events(req, ok, batt, cap);
        foreach (step_events[k]) expect_event(step_events[k]);
    endtask

    // drain, then give a word with no events time to clear the block
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        unique case (idx)
            CFG_POLICY_ENABLED:  pol_enabled = val[0];
            CFG_SAVER_MAX:       pol_saver_max = int'(val);
            CFG_BALANCED_MAX:    pol_balanced_max = int'(val);
            CFG_PERFORMANCE_MIN: pol_perf_min = int'(val);
            default: ;
        endcase
    endtask

    task automatic apply_policy(logic en, logic [6:0] saver, logic [6:0] balanced,
                                logic [6:0] perf);
        wait_idle();
        // upper bits of the enable word are don't-care
        write_reg(CFG_POLICY_ENABLED, {6'($urandom_range(63)), en});
        write_reg(CFG_SAVER_MAX, saver);
        write_reg(CFG_BALANCED_MAX, balanced);
        write_reg(CFG_PERFORMANCE_MIN, perf);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic req, logic ok, logic batt, logic [7:0] cap, int reps,
                           int n_typed, ev_word_t typed);
        stim_row_t r;
        r.req = req;
        r.ok = ok;
        r.batt = batt;
        r.cap = cap;
        r.reps = reps;
        r.n_typed = n_typed;
        r.typed = typed;
        stim_table.insert(stim_table.size(), r);
    endtask

    // mostly plausible charge/discharge walks, with ticks, bursts and noise
    task automatic run_random(int n_words);
        int done;
        int pick;
        int step;
        done = 0;
        while (done < n_words) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                step = $urandom_range(24, 20);
                repeat (step)
                    send_word(REQ_MINUTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              8'($urandom_range(255)));
                done += step;
            end else if (pick < 18) begin
                send_word(REQ_MINUTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                done++;
            end else if (pick < 24) begin
                send_word(REQ_SAMPLE, 1'b0, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                done++;
            end else if (pick < 30) begin
                send_word(REQ_SAMPLE, 1'b1, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                done++;
            end else begin
                if ($urandom_range(99) < 8 || (walk_batt && walk_soc <= 5 &&
                    $urandom_range(99) < 40) || (!walk_batt && walk_soc >= 100 &&
                    $urandom_range(99) < 15))
                    walk_batt = !walk_batt;
                step = $urandom_range(6);
                walk_soc = clamp_to(walk_batt ? walk_soc - step : walk_soc + step, -1, 100);
                send_word(REQ_SAMPLE, 1'b1, walk_batt, 8'(walk_soc));
                done++;
            end
        end
    endtask

    initial begin
        stim_row_t row;

        send_idle_pct = 23;
        recv_idle_pct <= 68;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(REQ_MINUTE, 1, 1, 8'hFF, 1, 0, '0);
        add_row(REQ_SAMPLE, 0, 1, 8'h7F, 1, 0, '0);   // unusable read before the first
        add_row(REQ_SAMPLE, 1, 0, 8'd50, 1, 1,
                make_word(EV_PROFILE, PROF_PERF, BRIGHT_PERF, URG_NONE, 8'd50, 1));
        add_row(REQ_SAMPLE, 1, 0, 8'd50, 1, 0, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'd80, 1, 1,
                make_word(EV_CHARGE, PROF_SAVER, '0, URG_NORMAL, 8'd80, 1));
        add_row(REQ_SAMPLE, 1, 0, 8'd100, 1, 1,
                make_word(EV_FULL, PROF_SAVER, '0, URG_NORMAL, 8'd100, 1));
        add_row(REQ_MINUTE, 0, 0, 8'h00, 25, 0, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'd100, 1, 1,
                make_word(EV_REMINDER, PROF_SAVER, '0, URG_NORMAL, 8'd100, 1));
        add_row(REQ_MINUTE, 1, 0, 8'h80, 2, 0, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'd100, 1, 0, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'd59, 1, 1,
                make_word(EV_PROFILE, PROF_BALANCED, BRIGHT_BALANCED, URG_LOW, 8'd59, 1));
        add_row(REQ_SAMPLE, 1, 1, 8'd60, 1, 1,
                make_word(EV_PROFILE, PROF_PERF, BRIGHT_PERF, URG_LOW, 8'd60, 1));
        add_row(REQ_SAMPLE, 1, 1, 8'd21, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'd20, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'hFF, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'h80, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'h7F, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 1, 8'h80, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'd90, 1, -1, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'd99, 1, -1, '0);
        add_row(REQ_SAMPLE, 0, 0, 8'hFF, 1, 0, '0);
        add_row(REQ_SAMPLE, 1, 0, 8'd100, 1, -1, '0);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            repeat (row.reps) begin
                offer_word(row.req, row.ok, row.batt, row.cap);
                derive_policy_events(row.req, row.ok, row.batt, row.cap);
                if (row.n_typed < 0) begin
                    foreach (step_events[k]) expect_event(step_events[k]);
                end else if (row.n_typed > 0) begin
                    expect_event(row.typed);
                end
            end
        end

        apply_policy(1'b1, 7'd20, 7'd59, 7'd60);
        run_random(12);
        apply_policy(1'b1, 7'd0, 7'd0, 7'd0);
        run_random(12);

        // output held off while words keep coming: the block must back up
        wait_idle();
        send_idle_pct = 0;
        hold_left <= 150;
        repeat (8) begin
            send_word(REQ_SAMPLE, 1'b1, 1'b0, 8'd90);
            send_word(REQ_SAMPLE, 1'b1, 1'b1, 8'd0);
        end
        wait_idle();

        send_idle_pct = 68;
        recv_idle_pct <= 23;
        apply_policy(1'b1, 7'd127, 7'd127, 7'd127);
        run_random(12);
        apply_policy(1'b0, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)));
        run_random(12);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        apply_policy(1'b1, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)));
        run_random(12);
        apply_policy(1'b1, 7'd30, 7'd10, 7'd50);
        run_random(12);

        wait_idle();
        if (mismatch_count == 0 && due_events.size() == 0) begin
            $display("tb_battery_power_policy_core: PASS");
        end else begin
            $display("tb_battery_power_policy_core: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bpp_pkg.sv
hw/rtl/battery_power_policy_core.sv
hw/rtl/bpp_checker.sv
sim/tb_battery_power_policy_core.sv
